/* hdl/per_channel_gain_saturate_macros.svh */
// Assertion macros for the per-channel gain block.
// Included by pcgs_peak, the RTL file that carries concurrent checks; no other dependency.
`ifndef PER_CHANNEL_GAIN_SATURATE_MACROS_SVH
`define PER_CHANNEL_GAIN_SATURATE_MACROS_SVH
`ifndef SYNTH
// Checked on rising clk, switched off while rst_n is low.
`define PCGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clk, reset included.
`define PCGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCGS_ASSERT(lbl, prop, msg)
`define PCGS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/pcgs_pkg.sv */
// Shared widths, register indexes, format codes and stage types for the gain block.
// No dependencies.
`timescale 1ns / 1ps

package pcgs_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int GAIN_W     = 31;
  localparam int CHAN_W     = 2;
  localparam int FMT_W      = 2;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = 64;

  localparam int MAX_CHANNELS_DEF   = 4;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN0  = 3'd2;

  // sample format codes
  localparam logic [FMT_W-1:0] FMT_16 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_24 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_32 = 2'd2;

  localparam logic [FMT_W-1:0]   FORMAT_RESET = FMT_32;
  localparam logic [COUNT_W-1:0] COUNT_RESET  = 3'd2;
  localparam logic [GAIN_W-1:0]  GAIN_RESET   = 31'd65536;

  localparam logic signed [SAMPLE_W-1:0] PEAK_RESET = 32'sh8000_0000;

  typedef struct packed {
    logic [FMT_W-1:0]   fmt;
    logic [COUNT_W-1:0] count;  // already clamped to 1..MAX_CHANNELS
  } pcgs_cfg_t;

  typedef struct packed {
    logic                       vld;
    logic [CHAN_W-1:0]          ch;
    logic                       last;
    logic signed [SAMPLE_W-1:0] y;
  } pcgs_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          ch;
    logic signed [SAMPLE_W-1:0] peak;
    logic                       last;
  } pcgs_res_t;

endpackage

/* hdl/pcgs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pcgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* hdl/pcgs_cfg.sv */
// Configuration registers: sample format, channel count and per-channel gains.
// Depends on pcgs_pkg.
`timescale 1ns / 1ps

module pcgs_cfg
  import pcgs_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output pcgs_cfg_t             cfg_o,
  output logic [GAIN_W-1:0]     gain_o [MAX_CHANNELS]
);

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CHANNELS);

  logic [FMT_W-1:0]     fmt_r;
  logic [COUNT_W-1:0]   count_r;
  logic [GAIN_W-1:0]    gain_r [MAX_CHANNELS];
  logic                 wr;
  logic [CFG_IDX_W-1:0] gidx;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign gidx      = cfg_index - CFG_GAIN0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FORMAT_RESET;
      count_r <= COUNT_RESET;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        gain_r[i] <= GAIN_RESET;
      end
    end else if (wr) begin
      if (cfg_index == CFG_FORMAT) begin
        fmt_r <= cfg_data[FMT_W-1:0];
      end
      if (cfg_index == CFG_COUNT) begin
        count_r <= cfg_data[COUNT_W-1:0];
      end
      // gains of channels the build does not have are dropped
      if (cfg_index >= CFG_GAIN0 && gidx < CFG_IDX_W'(MAX_CHANNELS)) begin
        gain_r[gidx[CH_W-1:0]] <= cfg_data[GAIN_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_o.fmt = fmt_r;
    if (count_r == '0) begin
      cfg_o.count = COUNT_W'(1);
    end else if (count_r > COUNT_MAX) begin
      cfg_o.count = COUNT_MAX;
    end else begin
      cfg_o.count = count_r;
    end
  end

  assign gain_o = gain_r;

endmodule

/* hdl/pcgs_scale.sv */
// Front pipeline: channel tracking, sign extension, gain multiply, round and saturate.
// Depends on pcgs_pkg.
`timescale 1ns / 1ps

module pcgs_scale
  import pcgs_pkg::*;
#(
  parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int CH_W           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic                       in_vld,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  input  pcgs_cfg_t                  cfg_i,
  input  logic [GAIN_W-1:0]          gain_i [MAX_CHANNELS],
  output pcgs_item_t                 item_o
);

  localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) << (GAIN_FRAC_BITS - 1);

  // channel counter
  logic [CHAN_W-1:0]  cnt_r, cnt_nxt, ch;
  logic [COUNT_W-1:0] ch_inc;
  logic               accept;

  // stage 1: operands
  logic                       s1_vld_r;
  logic signed [SAMPLE_W-1:0] s1_x_r, x_nxt;
  logic [GAIN_W-1:0]          s1_gain_r;
  logic [CHAN_W-1:0]          s1_ch_r;
  logic                       s1_last_r;

  // stage 2: product
  logic                     s2_vld_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic [CHAN_W-1:0]        s2_ch_r;
  logic                     s2_last_r;

  // stage 3: rounded, saturated
  logic signed [PROD_W-1:0] rsum, yw, lim_hi, lim_lo;
  pcgs_item_t               item_r, item_nxt;

  assign accept = in_vld && advance;
  assign ch     = ({1'b0, cnt_r} >= cfg_i.count) ? '0 : cnt_r;
  assign ch_inc = {1'b0, ch} + COUNT_W'(1);

  always_comb begin
    if (in_last || ch_inc >= cfg_i.count) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = ch_inc[CHAN_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_i.fmt)
      FMT_16:  x_nxt = {{16{in_sample[15]}}, in_sample[15:0]};
      FMT_24:  x_nxt = {{8{in_sample[23]}}, in_sample[23:0]};
      default: x_nxt = in_sample;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (advance) begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_x_r    <= x_nxt;
      s1_gain_r <= gain_i[ch[CH_W-1:0]];
      s1_ch_r   <= ch;
      s1_last_r <= in_last;
      // gain is unsigned, so zero-extend before the signed multiply
      s2_prod_r <= s1_x_r * $signed({1'b0, s1_gain_r});
      s2_ch_r   <= s1_ch_r;
      s2_last_r <= s1_last_r;
    end
  end

  always_comb begin
    unique case (cfg_i.fmt)
      FMT_16: begin
        lim_hi = PROD_W'(32767);
        lim_lo = -PROD_W'(32768);
      end
      FMT_24: begin
        lim_hi = PROD_W'(8388607);
        lim_lo = -PROD_W'(8388608);
      end
      default: begin
        lim_hi = PROD_W'(2147483647);
        lim_lo = -PROD_W'(64'sd2147483648);
      end
    endcase
    rsum          = s2_prod_r + RND;
    yw            = rsum >>> GAIN_FRAC_BITS;
    item_nxt.vld  = s2_vld_r;
    item_nxt.ch   = s2_ch_r;
    item_nxt.last = s2_last_r;
    if (yw > lim_hi) begin
      item_nxt.y = lim_hi[SAMPLE_W-1:0];
    end else if (yw < lim_lo) begin
      item_nxt.y = lim_lo[SAMPLE_W-1:0];
    end else begin
      item_nxt.y = yw[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (advance) begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

endmodule

/* hdl/pcgs_peak.sv */
// Peak tracker: read-modify-write of the per-channel peak RAM, and the output register.
// Depends on pcgs_pkg, pcgs_ram and per_channel_gain_saturate_macros.svh.
`timescale 1ns / 1ps
`include "per_channel_gain_saturate_macros.svh"

module pcgs_peak
  import pcgs_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pcgs_item_t item_i,
  input  logic       out_ready,
  output logic       advance,
  output logic       out_vld,
  output pcgs_res_t  res_o
);

  pcgs_item_t                 s4_r;
  logic [MAX_CHANNELS-1:0]    pk_vld_r;
  logic                       fwd_vld_r;
  logic [CH_W-1:0]            fwd_ch_r;
  logic signed [SAMPLE_W-1:0] fwd_val_r;
  logic                       out_vld_r;
  pcgs_res_t                  res_r, res_nxt;

  logic [CH_W-1:0]            raddr, s4_ch;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] old_pk, new_pk;
  logic                       we;

  assign advance = !out_vld_r || out_ready;
  assign s4_ch   = s4_r.ch[CH_W-1:0];
  // on a stall keep reading the held item's entry so read data stays aligned
  assign raddr   = advance ? item_i.ch[CH_W-1:0] : s4_ch;
  assign we      = advance && s4_r.vld;

  pcgs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_CHANNELS)
  ) u_peak_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s4_ch),
    .wdata (new_pk),
    .raddr (raddr),
    .rdata (rdata)
  );

  // the RAM returns pre-write data, so the latest write is forwarded
  always_comb begin
    if (!pk_vld_r[s4_ch]) begin
      old_pk = PEAK_RESET;
    end else if (fwd_vld_r && fwd_ch_r == s4_ch) begin
      old_pk = fwd_val_r;
    end else begin
      old_pk = $signed(rdata);
    end
    new_pk         = (s4_r.y > old_pk) ? s4_r.y : old_pk;
    res_nxt.sample = s4_r.y;
    res_nxt.ch     = s4_r.ch;
    res_nxt.peak   = new_pk;
    res_nxt.last   = s4_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.vld  <= 1'b0;
      out_vld_r <= 1'b0;
      pk_vld_r  <= '0;
      fwd_vld_r <= 1'b0;
    end else if (advance) begin
      s4_r      <= item_i;
      out_vld_r <= s4_r.vld;
      if (we) begin
        if (s4_r.last) begin
          // end of block: every peak reads as reset from here on
          pk_vld_r  <= '0;
          fwd_vld_r <= 1'b0;
        end else begin
          pk_vld_r[s4_ch] <= 1'b1;
          fwd_vld_r       <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
    if (we) begin
      fwd_ch_r  <= s4_ch;
      fwd_val_r <= new_pk;
    end
  end

  assign out_vld = out_vld_r;
  assign res_o   = res_r;

  `PCGS_ASSERT(a_peak_ge_sample, out_vld_r |-> (res_r.peak >= res_r.sample), "peak below sample")
  `PCGS_ASSERT(a_block_clear, (we && s4_r.last) |=> (pk_vld_r == '0 && !fwd_vld_r), "peaks not cleared at block end")
  `PCGS_ASSERT_ALWAYS(a_fwd_entry_live, fwd_vld_r |-> pk_vld_r[fwd_ch_r], "forward entry not valid")
  `PCGS_ASSERT(a_write_loads_out, we |=> out_vld_r, "peak written without a result")

endmodule

/* hdl/per_channel_gain_saturate.sv */
// Top level of the per-channel gain, round, saturate and peak block.
// Depends on pcgs_pkg, pcgs_cfg, pcgs_scale, pcgs_peak (and through it pcgs_ram).
`timescale 1ns / 1ps

// Scales an interleaved signed audio stream by a Q-format gain per channel
// (GAIN_FRAC_BITS fraction bits, unity 1 << 16 at reset), rounds half up,
// saturates to the 16, 24 or 32 bit format and reports each channel's running
// peak within the current block. One sample is accepted every cycle unless a result
// waiting on out_tready stalls the pipeline; results pass the operand, multiply,
// round and saturate, peak read and output registers. The peaks live in a small RAM
// that is read as each item enters the peak read stage and written back with forwarding
// of the last write, so consecutive samples of the same channel do not stall. At reset
// and after a transaction with in_tlast set, all peaks read as the most negative value
// and the channel counter restarts at 0, with no clear pass. Registers: 0 format,
// 1 channel count, 2.. gains per channel; write them only while idle.

module per_channel_gain_saturate
  import pcgs_pkg::*;
#(
  parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [31:0] sample_in
  input  logic                  in_tlast,   // block_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata,  // [31:0] sample_out, [33:32] channel_index,
                                            // [65:34] channel_peak, [71:66] zero
  output logic                  out_tlast,  // block_done
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pcgs_cfg_t         cfg;
  logic [GAIN_W-1:0] gain [MAX_CHANNELS];
  pcgs_item_t        item;
  pcgs_res_t         res;
  logic              advance;

  pcgs_cfg #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg),
    .gain_o    (gain)
  );

  pcgs_scale #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_vld    (in_tvalid),
    .in_sample ($signed(in_tdata)),
    .in_last   (in_tlast),
    .cfg_i     (cfg),
    .gain_i    (gain),
    .item_o    (item)
  );

  pcgs_peak #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_peak (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_i    (item),
    .out_ready (out_tready),
    .advance   (advance),
    .out_vld   (out_tvalid),
    .res_o     (res)
  );

  assign in_tready = advance;
  assign out_tdata = {6'd0, res.peak, res.ch, res.sample};
  assign out_tlast = res.last;

endmodule
